// ===== rtl/sorted_priority_queue_top_assert.svh =====
// Assertion macros used by the queue top level.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

	localparam int DATA_W = 32;

	// Operation codes carried in the mode field.
	localparam logic [1:0] MODE_INS = 2'd0;
	localparam logic [1:0] MODE_POP = 2'd1;
	localparam logic [1:0] MODE_REM = 2'd2;
	localparam logic [1:0] MODE_CHG = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	localparam logic [DATA_W-1:0] NEG_ONE = '1;

	// What every cell does in a given cycle.
	typedef enum logic [1:0] {
		CMD_HOLD = 2'd0,
		CMD_INS  = 2'd1,
		CMD_REM  = 2'd2
	} cell_cmd_t;

	// Broadcast from the controller to all cells.
	typedef struct packed {
		cell_cmd_t         cmd;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] prio;
	} cell_bcast_t;

	// Contents of one cell as seen by its neighbors.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] prio;
	} cell_link_t;

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
module spq_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 7
) (
	input  logic                     clk,
	input  logic [CNT_W-1:0]         count,
	input  spq_pkg::cell_bcast_t     bcast,
	input  spq_pkg::cell_link_t      left,
	input  logic                     left_ge,
	input  spq_pkg::cell_link_t      right,
	input  logic                     hit_in,
	output spq_pkg::cell_link_t      cur,
	output logic                     ge,
	output logic                     hit_out,
	output logic [spq_pkg::DATA_W-1:0] nxt_value
);
	import spq_pkg::*;

	cell_link_t entry_q;
	cell_link_t entry_d;
	logic       occ;
	logic       match;

	assign occ   = CNT_W'(INDEX) < count;
	// Sorted order keeps all entries of equal or higher priority in a prefix.
	assign ge    = occ && ($signed(entry_q.prio) >= $signed(bcast.prio));
	assign match = occ && (entry_q.prio == bcast.prio);
	// Prefix flag: set from the first matching entry onward, or from cell zero when seeded.
	assign hit_out = hit_in | match;

	always_comb begin
		entry_d = entry_q;
		case (bcast.cmd)
			CMD_INS: begin
				if (!ge) begin
					if (left_ge) begin
						entry_d.value = bcast.value;
						entry_d.prio  = bcast.prio;
					end else begin
						entry_d = left;
					end
				end
			end
			CMD_REM: begin
				if (hit_out) begin
					entry_d = right;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign cur       = entry_q;
	assign nxt_value = entry_d.value;

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps
// Flow: an accepted beat is registered, then run in EXEC, whose shift of the cell chain
// also loads the output register; a change that finds its entry runs a remove shift in
// EXEC and then an insert shift in REINS, which loads the output register.
// Only one operation is in flight: no new beat is taken until the controller is back in
// IDLE and the output slot is free or being emptied.
// Reset: arst_n clears the entry count, the controller and the output valid at once;
// the entry storage is not cleared, and only entries below the count are ever read.
module sorted_priority_queue_top #(
	parameter int CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0: mode[1:0], value[33:2], priority_req[65:34], new_priority[97:66].
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0: popped_value[31:0], status[33:32], head_value[65:34],
	// head_valid[66], entry_count[73:67].
	output logic [79:0]  m_tdata
);
	import spq_pkg::*;
	`include "sorted_priority_queue_top_assert.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EXEC  = 3'b010,
		ST_REINS = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// The accepted operation, held while the cell chain works on it.
	logic [1:0]        mode_q;
	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] preq_q;
	logic [DATA_W-1:0] pnew_q;
	// Value of the entry that a change lifted out, waiting to be put back.
	logic [DATA_W-1:0] carry_q;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] out_popped_q;
	logic [1:0]        out_status_q;
	logic [DATA_W-1:0] out_head_q;
	logic              out_head_valid_q;
	logic [6:0]        out_count_q;

	// Cell chain wiring.
	cell_bcast_t       bcast;
	logic              hit_seed;
	cell_link_t        cur  [CAPACITY];
	logic [DATA_W-1:0] nxt_value [CAPACITY];
	logic [CAPACITY-1:0] ge;
	logic [CAPACITY-1:0] hit;
	logic              found;
	logic [DATA_W-1:0] sel_value;

	// Per-operation result.
	logic              load_out;
	logic [DATA_W-1:0] popped_d;
	logic [1:0]        status_d;
	logic [CNT_W+6:0]  count_ext;

	logic in_accept;
	logic out_accept;

	assign in_accept  = s_tvalid && s_tready;
	assign out_accept = out_valid_q && m_tready;
	// Only one operation is in flight; the output slot must be free, or be emptied
	// at the same edge, before the next beat comes in.
	assign s_tready   = (state_q == ST_IDLE) && (!out_valid_q || m_tready);

	// The row of cells. Each cell sees its neighbors' contents; the equal-or-higher
	// flag runs left to right for insertion, the match flag forms a prefix for removal.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_link_t left_link;
		cell_link_t right_link;
		logic       left_ge;
		logic       hit_in;

		if (i == 0) begin : g_first
			assign left_link = cur[0];
			assign left_ge   = 1'b1;
			assign hit_in    = hit_seed;
		end else begin : g_inner
			assign left_link = cur[i-1];
			assign left_ge   = ge[i-1];
			assign hit_in    = hit[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_link = cur[i];
		end else begin : g_body
			assign right_link = cur[i+1];
		end

		spq_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.count     (count_q),
			.bcast     (bcast),
			.left      (left_link),
			.left_ge   (left_ge),
			.right     (right_link),
			.hit_in    (hit_in),
			.cur       (cur[i]),
			.ge        (ge[i]),
			.hit_out   (hit[i]),
			.nxt_value (nxt_value[i])
		);
	end

	assign found = hit[CAPACITY-1];

	// Value of the first matching entry: the single cell where the prefix flag rises.
	always_comb begin
		sel_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit[i] && ((i == 0) ? !hit_seed : !hit[(i == 0) ? 0 : i - 1])) begin
				sel_value = sel_value | cur[i].value;
			end
		end
	end

	// What the cells do this cycle depends only on the state, the held operation, the lifted
	// value and the count, not on this cycle's search, so no path feeds back into the chain.
	always_comb begin
		bcast.cmd   = CMD_HOLD;
		bcast.value = value_q;
		bcast.prio  = preq_q;
		hit_seed    = 1'b0;
		case (state_q)
			ST_EXEC: begin
				case (mode_q)
					MODE_INS: begin
						if (count_q != CNT_W'(CAPACITY)) begin
							bcast.cmd = CMD_INS;
						end
					end
					MODE_POP: begin
						if (count_q != '0) begin
							bcast.cmd = CMD_REM;
							hit_seed  = 1'b1;
						end
					end
					MODE_REM: begin
						if (count_q != '0) begin
							bcast.cmd = CMD_REM;
						end
					end
					MODE_CHG: begin
						bcast.cmd = CMD_REM;
					end
					default: begin
						bcast.cmd = CMD_HOLD;
					end
				endcase
			end
			ST_REINS: begin
				// Put the lifted entry back under its new priority.
				bcast.cmd   = CMD_INS;
				bcast.value = carry_q;
				bcast.prio  = pnew_q;
			end
			default: begin
				bcast.cmd = CMD_HOLD;
			end
		endcase
	end

	// Controller: decides the next state and what the result says.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		load_out    = 1'b0;
		popped_d    = '0;
		status_d    = STAT_OK;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				load_out = 1'b1;
				state_d  = ST_IDLE;
				case (mode_q)
					MODE_INS: begin
						if (count_q == CNT_W'(CAPACITY)) begin
							status_d = STAT_FULL;
						end else begin
							count_d   = count_q + 1'b1;
						end
					end
					MODE_POP: begin
						if (count_q == '0) begin
							status_d = STAT_EMPTY;
							popped_d = NEG_ONE;
						end else begin
							popped_d  = cur[0].value;
							count_d   = count_q - 1'b1;
						end
					end
					MODE_REM: begin
						if (count_q == '0) begin
							status_d = STAT_EMPTY;
						end else begin
							if (found) begin
								count_d = count_q - 1'b1;
							end else begin
								status_d = STAT_NOTFOUND;
							end
						end
					end
					MODE_CHG: begin
						if (found) begin
							count_d  = count_q - 1'b1;
							load_out = 1'b0;
							state_d  = ST_REINS;
						end else begin
							status_d = STAT_NOTFOUND;
						end
					end
					default: begin
						status_d = STAT_OK;
					end
				endcase
			end
			ST_REINS: begin
				count_d     = count_q + 1'b1;
				load_out    = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign count_ext = {7'd0, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_accept) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q  <= s_tdata[1:0];
			value_q <= s_tdata[33:2];
			preq_q  <= s_tdata[65:34];
			pnew_q  <= s_tdata[97:66];
		end
		if (state_q == ST_EXEC) begin
			carry_q <= sel_value;
		end
		if (load_out) begin
			out_popped_q     <= popped_d;
			out_status_q     <= status_d;
			// The head after this cycle's shift is what cell zero loads now.
			out_head_q       <= (count_d != '0) ? nxt_value[0] : NEG_ONE;
			out_head_valid_q <= (count_d != '0);
			out_count_q      <= count_ext[6:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_count_q, out_head_valid_q, out_head_q, out_status_q,
		out_popped_q};

	`SPQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY),
		"entry count exceeds capacity")
	`SPQ_ASSERT_NXT(a_insert_grows, clk, arst_n, bcast.cmd == CMD_INS,
		count_q == $past(count_q) + 1'b1, "insert did not add one entry")
	`SPQ_ASSERT_IMP(a_full_status, clk, arst_n, out_valid_q && out_status_q == STAT_FULL,
		count_q == CNT_W'(CAPACITY), "full status reported while queue not full")

endmodule
